/* sv/sorted_priority_queue_defines.svh */
// assertion macros for the sorted priority queue
// expects clk and arst_n in the scope of each use
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// property that must hold at every edge outside reset
`define SPQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/spq_pkg.sv */
// types and constants shared by the sorted priority queue modules
// no dependencies
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OCC_W    = 5;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic               action;
		logic signed [31:0] in_data;
		logic        [7:0]  in_priority;
	} req_t;

	typedef struct packed {
		logic signed [31:0] out_data;
		logic        [7:0]  out_priority;
		status_t            status;
		logic [OCC_W-1:0]   occupancy;
	} rsp_t;

	// one slot of the sorted list
	typedef struct packed {
		logic               valid;
		logic        [7:0]  prio;
		logic signed [31:0] data;
	} entry_t;

	// broadcast to every cell
	typedef struct packed {
		logic               ins;
		logic               rem;
		logic        [7:0]  prio;
		logic signed [31:0] data;
	} cell_ctrl_t;

endpackage

/* sv/spq_cell.sv */
// one slot of the sorted chain: keeps, shifts or takes the new entry
// depends on spq_pkg
module spq_cell import spq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  entry_t     left,
	input  entry_t     right,
	output entry_t     cur
);

	logic        valid_q;
	logic [7:0]  prio_q;
	logic signed [31:0] data_q;
	entry_t      nxt;
	logic        keep;
	logic        left_keep;
	logic        left_moves;

	assign cur = '{valid: valid_q, prio: prio_q, data: data_q};

	assign keep       = valid_q && (prio_q <= ctrl.prio);
	assign left_keep  = left.valid && (left.prio <= ctrl.prio);
	assign left_moves = left.valid && (left.prio > ctrl.prio);

	always_comb begin
		nxt = cur;
		if (ctrl.ins) begin
			if (keep) begin
				nxt = cur;
			end else if (left_moves) begin
				nxt = left;
			end else if (left_keep) begin
				// first slot past every entry of lower or equal priority
				nxt = '{valid: 1'b1, prio: ctrl.prio, data: ctrl.data};
			end
		end else if (ctrl.rem) begin
			nxt = right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		prio_q <= nxt.prio;
		data_q <= nxt.data;
	end

endmodule

/* sv/spq_out_buf.sv */
// two-entry response buffer: output register plus skid register
// depends on spq_pkg
module spq_out_buf import spq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rsp_t push_rsp,
	output logic space,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic out_valid_q;
	logic skid_valid_q;
	rsp_t out_q;
	rsp_t skid_q;
	logic pop;

	assign space     = !skid_valid_q;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;
	assign pop       = out_valid_q && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (push) begin
				if (out_valid_q && !pop) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (pop) begin
				out_valid_q  <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (out_valid_q && !pop) begin
				skid_q <= push_rsp;
			end else begin
				out_q <= push_rsp;
			end
		end else if (pop && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

endmodule

/* sv/sorted_priority_queue.sv */
// Sorted priority queue of CAPACITY entries, smallest priority value served first.
// Requests arrive on req_valid/req_ready/req: action selects insert or remove of
// the head; insert carries in_data and in_priority. Each request gives exactly
// one response on rsp_valid/rsp_ready/rsp with the removed data and priority
// (zero otherwise), a status (ok, remove from empty, insert into full with the
// entry dropped) and the occupancy after the request.
// Entries sit in a row of cells in ascending order; every cell compares its own
// priority with the new one in parallel and either holds, takes its neighbor's
// entry or takes the new entry, so the whole list moves at once.
// The response is registered in spq_out_buf before it shows on rsp.
// Throughput: one request per cycle while req_ready is high, set by the parallel cell update.
// Equal priorities leave in arrival order.
// Reset clears all slot valid bits and the count; slot contents are not reset.
// When the receiver stalls, one further response goes to a skid register and
// req_ready then drops until the receiver takes a response.
// depends on spq_pkg, spq_cell, spq_out_buf and sorted_priority_queue_defines.svh
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue import spq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_nxt;
	logic                accept;
	logic                full;
	logic                empty;
	cell_ctrl_t          ctrl;
	entry_t              cells [CAPACITY];
	logic [CAPACITY-1:0] valid_vec;
	rsp_t                new_rsp;

	assign accept = req_valid && req_ready;
	assign full   = (count_q == CNT_W'(CAPACITY));
	assign empty  = (count_q == '0);

	assign ctrl.ins  = accept && (req.action == ACT_INSERT) && !full;
	assign ctrl.rem  = accept && (req.action == ACT_REMOVE) && !empty;
	assign ctrl.prio = req.in_priority;
	assign ctrl.data = req.in_data;

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			entry_t left_e;
			entry_t right_e;
			if (i == 0) begin : g_head
				// boundary behaves as a held entry of the lowest priority
				assign left_e = '{valid: 1'b1, prio: 8'd0, data: 32'sd0};
			end else begin : g_mid
				assign left_e = cells[i-1];
			end
			if (i == CAPACITY - 1) begin : g_tail
				assign right_e = '{valid: 1'b0, prio: 8'd0, data: 32'sd0};
			end else begin : g_body
				assign right_e = cells[i+1];
			end
			spq_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctrl   (ctrl),
				.left   (left_e),
				.right  (right_e),
				.cur    (cells[i])
			);
			assign valid_vec[i] = cells[i].valid;
		end
	endgenerate

	always_comb begin
		count_nxt = count_q;
		if (ctrl.ins) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (ctrl.rem) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	always_comb begin
		new_rsp.out_data     = 32'sd0;
		new_rsp.out_priority = 8'd0;
		new_rsp.status       = STATUS_OK;
		new_rsp.occupancy    = OCC_W'(count_nxt);
		if (req.action == ACT_REMOVE) begin
			if (empty) begin
				new_rsp.status = STATUS_EMPTY;
			end else begin
				new_rsp.out_data     = cells[0].data;
				new_rsp.out_priority = cells[0].prio;
			end
		end else if (full) begin
			new_rsp.status = STATUS_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	spq_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_rsp  (new_rsp),
		.space     (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	`SPQ_ASSERT(a_valid_packed, (valid_vec & CAPACITY'(valid_vec + 1'b1)) == '0, "valid slots not packed at head")
	`SPQ_ASSERT(a_count_match, $countones(valid_vec) == 32'(count_q), "count disagrees with valid slots")
	`SPQ_ASSERT_NEXT(a_remove_dec, ctrl.rem, count_q == $past(count_q) - CNT_W'(1), "remove did not drop count")
	`SPQ_ASSERT_NEXT(a_insert_inc, ctrl.ins, count_q == $past(count_q) + CNT_W'(1), "insert did not raise count")

endmodule

/* dv/testbench.sv */
// testbench for the sorted priority queue: directed fill/drain then long random runs
// a scoreboard class tracks the held entries and checks every response field
// depends on spq_pkg and sorted_priority_queue
module testbench;
	import spq_pkg::*;

	localparam int RANDOM_ITEMS = 1400;
	localparam int HOLD_CYCLES  = 60;

	class prio_queue_checker;
		entry_t held_entries[$];
		rsp_t   expected_rsp[$];
		int     mismatches = 0;

		task report(string msg);
			$display("mismatch: %s", msg);
			mismatches++;
		endtask

		// update the tracked list and queue the response this request must give
		function void note_request(req_t r);
			rsp_t   exp;
			entry_t e;
			int     pos;
			exp = '0;
			exp.status = STATUS_OK;
			if (r.action == ACT_INSERT) begin
				if (held_entries.size() >= CAPACITY) begin
					exp.status = STATUS_FULL;
				end else begin
					// place after every entry of lower or equal priority
					pos = 0;
					while (pos < held_entries.size() && held_entries[pos].prio <= r.in_priority)
						pos++;
					e.valid = 1'b1;
					e.prio  = r.in_priority;
					e.data  = r.in_data;
					held_entries.insert(pos, e);
				end
			end else if (held_entries.size() == 0) begin
				exp.status = STATUS_EMPTY;
			end else begin
				e = held_entries.pop_front();
				exp.out_data     = e.data;
				exp.out_priority = e.prio;
			end
			exp.occupancy = OCC_W'(held_entries.size());
			expected_rsp.push_back(exp);
		endfunction

		task check_response(rsp_t got);
			rsp_t exp;
			if (expected_rsp.size() == 0) begin
				report($sformatf("response with no request pending: %p", got));
				return;
			end
			exp = expected_rsp.pop_front();
			if (got.out_data !== exp.out_data)
				report($sformatf("out_data got %0d expected %0d", got.out_data, exp.out_data));
			if (got.out_priority !== exp.out_priority)
				report($sformatf("out_priority got %0d expected %0d",
					got.out_priority, exp.out_priority));
			if (got.status !== exp.status)
				report($sformatf("status got %0d expected %0d", got.status, exp.status));
			if (got.occupancy !== exp.occupancy)
				report($sformatf("occupancy got %0d expected %0d", got.occupancy, exp.occupancy));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	logic calm      = 1'b0;
	logic stall_rsp = 1'b0;
	logic [7:0] fill_prio [16] = '{8'd255, 8'd0, 8'd7, 8'd7, 8'd7, 8'd0, 8'd255, 8'd128,
		8'd1, 8'd254, 8'd7, 8'd64, 8'd0, 8'd200, 8'd3, 8'd127};

	prio_queue_checker chk;

	sorted_priority_queue u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("testbench NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && req_valid && req_ready)
			chk.note_request(req);
		if (arst_n && rsp_valid && rsp_ready)
			chk.check_response(rsp);
	end

	// receiver: random backpressure, one long hold when the sender asks for it
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_rsp) begin
				stall_rsp = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= calm || ($urandom_range(99) >= 34);
			end
		end
	end

	task send_request(input logic act, input logic signed [31:0] data, input logic [7:0] prio);
		req_t r;
		r.action      = act;
		r.in_data     = data;
		r.in_priority = prio;
		while (!calm && $urandom_range(99) < 34) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
	endtask

	initial begin
		int         sent;
		int         phase_len;
		int         ins_pct;
		int         prio_mode;
		logic [7:0] p;
		logic       act;
		logic signed [31:0] d;

		chk       = new();
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// remove on empty, fill past full with ties and extreme values, partial drain
		send_request(ACT_REMOVE, $urandom, 8'($urandom));
		for (int i = 0; i < 16; i++) begin
			case (i)
				0: d = 32'sh7fffffff;
				1: d = 32'sh80000000;
				2: d = -32'sd1;
				3: d = 32'sd0;
				default: d = $urandom;
			endcase
			send_request(ACT_INSERT, d, fill_prio[i]);
		end
		send_request(ACT_INSERT, 32'sh5a5a5a5a, 8'd0);
		repeat (6) send_request(ACT_REMOVE, $urandom, 8'($urandom));

		// random phases that lean toward filling or draining
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			phase_len = $urandom_range(80, 10);
			case ($urandom_range(3))
				0: ins_pct = 15;
				1: ins_pct = 50;
				2: ins_pct = 80;
				default: ins_pct = 97;
			endcase
			prio_mode = $urandom_range(2);
			repeat (phase_len) begin
				calm = (sent >= 500 && sent < 700);
				if (sent == 1000)
					stall_rsp = 1'b1;
				case (prio_mode)
					0: p = 8'($urandom_range(255));
					1: p = 8'($urandom_range(3));
					default: p = $urandom_range(1) ? 8'd255 : 8'd0;
				endcase
				act = ($urandom_range(99) < ins_pct) ? ACT_INSERT : ACT_REMOVE;
				send_request(act, $urandom, p);
				sent++;
			end
		end
		req_valid <= 1'b0;
		calm = 1'b0;

		while (chk.expected_rsp.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (chk.expected_rsp.size() != 0)
			chk.report($sformatf("%0d responses never arrived", chk.expected_rsp.size()));

		if (chk.mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
